FILE: rtl/adcsss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_pkg
// Shared types, register codes and constants of the scan, scale and smooth
// block.
// ----------------------------------------------------------------------------
package adcsss_pkg;

   // Channel codes, in scan order
   localparam logic [1:0] CH_TEMP = 2'd0;
   localparam logic [1:0] CH_VOLT = 2'd1;
   localparam logic [1:0] CH_CURR = 2'd2;

   // Converter mux codes
   localparam logic [7:0] MUX_TEMP = 8'h42;
   localparam logic [7:0] MUX_VOLT = 8'h03;
   localparam logic [7:0] MUX_CURR = 8'h04;

   // Arithmetic constants
   localparam logic [13:0]        MV_PER_LSB_Q16 = 14'd10000;
   localparam logic [31:0]        TEMP_ROUND     = 32'h0000_0800;
   localparam logic signed [32:0] KELVIN_Q16     = 33'sd17901158;
   localparam logic signed [51:0] GAIN_ROUND     = 52'sd128;
   localparam logic signed [51:0] SMOOTH_ROUND   = 52'sd32768;
   localparam logic [16:0]        ALPHA_ONE      = 17'd65536;

   // Register reset values
   localparam logic [15:0]        VOLTAGE_GAIN_RST   = 16'd768;
   localparam logic [15:0]        CURRENT_GAIN_RST   = 16'd128;
   localparam logic signed [23:0] VOLTAGE_BIAS_RST   = 24'sd0;
   localparam logic signed [23:0] CURRENT_BIAS_RST   = 24'sd0;
   localparam logic [16:0]        TEMP_ALPHA_RST     = 17'd13107;
   localparam logic [16:0]        VOLTAGE_ALPHA_RST  = 17'd13107;
   localparam logic [16:0]        CURRENT_ALPHA_RST  = 17'd655;
   localparam logic [31:0]        TEMP_CAL_RST       = 32'd0;

   typedef enum logic [2:0] {
      REG_VOLTAGE_GAIN  = 3'd0,
      REG_CURRENT_GAIN  = 3'd1,
      REG_VOLTAGE_BIAS  = 3'd2,
      REG_CURRENT_BIAS  = 3'd3,
      REG_TEMP_ALPHA    = 3'd4,
      REG_VOLTAGE_ALPHA = 3'd5,
      REG_CURRENT_ALPHA = 3'd6,
      REG_TEMP_CAL      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        voltage_gain;
      logic [15:0]        current_gain;
      logic signed [23:0] voltage_bias;
      logic signed [23:0] current_bias;
      logic [16:0]        temp_alpha;
      logic [16:0]        voltage_alpha;
      logic [16:0]        current_alpha;
      logic [31:0]        temp_calibration;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_VALUE,
      ST_SMOOTH,
      ST_UPDATE
   } state_type;

   // Datapath steps, one hot per cycle
   typedef struct packed {
      logic load;
      logic scale;
      logic value;
      logic smooth;
      logic commit;
   } cmd_type;

endpackage

FILE: rtl/adcsss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_req_if / adcsss_rsp_if
// Valid/ready channels for converter samples and smoothed results.
// ----------------------------------------------------------------------------
interface adcsss_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface adcsss_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         channel;
   logic signed [31:0] smoothed_value;
   logic [7:0]         next_mux;

   modport source (output valid, output channel, output smoothed_value,
                   output next_mux, input ready);
   modport sink (input valid, input channel, input smoothed_value,
                 input next_mux, output ready);
endinterface

FILE: rtl/adc_scan_scale_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_scale_smooth
// Scans temperature, voltage and current samples, scales each to Q16.16 and
// keeps a per-channel exponential moving average.
// ----------------------------------------------------------------------------
// Sequencing: the sequencer walks load, scale, value, smooth and update through
//   a single shared 34x18 multiplier, and accepts a new sample only in the idle
//   state, once the previous one has been committed.
// A waiting result holds in the output register; the update step stalls until
//   it is taken.
// Reset: synchronous; clears the averages, points at temperature and loads
//   register defaults.
// ----------------------------------------------------------------------------
module adc_scan_scale_smooth (
   input  logic                clock,
   input  logic                reset,
   adcsss_req_if.sink          req_bus,
   adcsss_rsp_if.source        rsp_bus,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   adcsss_pkg::cfg_type cfg;
   adcsss_pkg::cmd_type cmd;
   logic                req_ready;
   logic                rsp_valid;
   logic [1:0]          rsp_channel;
   logic signed [31:0]  rsp_smoothed_value;
   logic [7:0]          rsp_next_mux;

   adcsss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adcsss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   adcsss_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_sample         (req_bus.sample),
      .rsp_channel        (rsp_channel),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_next_mux       (rsp_next_mux)
   );

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.channel        = rsp_channel;
   assign rsp_bus.smoothed_value = rsp_smoothed_value;
   assign rsp_bus.next_mux       = rsp_next_mux;

endmodule

FILE: rtl/adcsss_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module adcsss_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output adcsss_pkg::cfg_type cfg
);

   adcsss_pkg::cfg_type cfg_ff;
   adcsss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (adcsss_pkg::reg_index_type'(csr_index))
            adcsss_pkg::REG_VOLTAGE_GAIN:  cfg_in.voltage_gain     = csr_wdata[15:0];
            adcsss_pkg::REG_CURRENT_GAIN:  cfg_in.current_gain     = csr_wdata[15:0];
            adcsss_pkg::REG_VOLTAGE_BIAS:  cfg_in.voltage_bias     = csr_wdata[23:0];
            adcsss_pkg::REG_CURRENT_BIAS:  cfg_in.current_bias     = csr_wdata[23:0];
            adcsss_pkg::REG_TEMP_ALPHA:    cfg_in.temp_alpha       = csr_wdata[16:0];
            adcsss_pkg::REG_VOLTAGE_ALPHA: cfg_in.voltage_alpha    = csr_wdata[16:0];
            adcsss_pkg::REG_CURRENT_ALPHA: cfg_in.current_alpha    = csr_wdata[16:0];
            adcsss_pkg::REG_TEMP_CAL:      cfg_in.temp_calibration = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_gain     <= adcsss_pkg::VOLTAGE_GAIN_RST;
         cfg_ff.current_gain     <= adcsss_pkg::CURRENT_GAIN_RST;
         cfg_ff.voltage_bias     <= adcsss_pkg::VOLTAGE_BIAS_RST;
         cfg_ff.current_bias     <= adcsss_pkg::CURRENT_BIAS_RST;
         cfg_ff.temp_alpha       <= adcsss_pkg::TEMP_ALPHA_RST;
         cfg_ff.voltage_alpha    <= adcsss_pkg::VOLTAGE_ALPHA_RST;
         cfg_ff.current_alpha    <= adcsss_pkg::CURRENT_ALPHA_RST;
         cfg_ff.temp_calibration <= adcsss_pkg::TEMP_CAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/adcsss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_ctrl
// Sequencer: steps the datapath through scale, value, smooth and update, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module adcsss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output adcsss_pkg::cmd_type cmd
);

   adcsss_pkg::state_type state_ff;
   adcsss_pkg::state_type state_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adcsss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         adcsss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = adcsss_pkg::ST_SCALE;
            end
         end
         adcsss_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = adcsss_pkg::ST_VALUE;
         end
         adcsss_pkg::ST_VALUE: begin
            cmd.value = 1'b1;
            state_in  = adcsss_pkg::ST_SMOOTH;
         end
         adcsss_pkg::ST_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = adcsss_pkg::ST_UPDATE;
         end
         adcsss_pkg::ST_UPDATE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = adcsss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcsss_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over an untaken beat");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == adcsss_pkg::ST_SCALE))
      else $error("accepted beat did not start the scale step");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == adcsss_pkg::ST_UPDATE))
      else $error("result raised outside the update step");

endmodule

FILE: rtl/adcsss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_dp
// Datapath: channel pointer, averages, one shared 34x18 multiplier and the
// result register.
// ----------------------------------------------------------------------------
module adcsss_dp (
   input  logic                clock,
   input  logic                reset,
   input  adcsss_pkg::cmd_type cmd,
   input  adcsss_pkg::cfg_type cfg,
   input  logic [13:0]         req_sample,
   output logic [1:0]          rsp_channel,
   output logic signed [31:0]  rsp_smoothed_value,
   output logic [7:0]          rsp_next_mux
);

   function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
      logic signed [31:0] r;
      if (x[51:31] == {21{x[51]}}) begin
         r = x[31:0];
      end else if (x[51]) begin
         r = {1'b1, 31'd0};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   logic [1:0]         ch_ff;
   logic [1:0]         ch_in;
   logic [1:0]         chn;
   logic               is_temp;
   logic signed [31:0] avg_ff [3];
   logic signed [31:0] avg_cur;
   logic signed [33:0] opa_ff;
   logic signed [33:0] opa_in;
   logic signed [51:0] prod_ff;
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] mul_p;
   logic [27:0]        mv;
   logic signed [33:0] vsum;
   logic [31:0]        tdiff;
   logic [31:0]        tround;
   logic signed [32:0] tval;
   logic signed [51:0] gval;
   logic signed [31:0] value;
   logic signed [32:0] diff;
   logic [16:0]        alpha_raw;
   logic [16:0]        alpha;
   logic [15:0]        gain;
   logic signed [23:0] bias;
   logic signed [51:0] acc;
   logic signed [31:0] avg_new;
   logic [7:0]         mux_next;
   logic [1:0]         rsp_channel_ff;
   logic signed [31:0] rsp_value_ff;
   logic [7:0]         rsp_mux_ff;

   // an unused pointer code acts as temperature
   assign chn     = (ch_ff == 2'd3) ? adcsss_pkg::CH_TEMP : ch_ff;
   assign is_temp = (chn == adcsss_pkg::CH_TEMP);
   assign avg_cur = avg_ff[chn];

   always_comb begin
      unique case (chn)
         adcsss_pkg::CH_VOLT: begin
            gain      = cfg.voltage_gain;
            bias      = cfg.voltage_bias;
            alpha_raw = cfg.voltage_alpha;
            ch_in     = adcsss_pkg::CH_CURR;
            mux_next  = adcsss_pkg::MUX_CURR;
         end
         adcsss_pkg::CH_CURR: begin
            gain      = cfg.current_gain;
            bias      = cfg.current_bias;
            alpha_raw = cfg.current_alpha;
            ch_in     = adcsss_pkg::CH_TEMP;
            mux_next  = adcsss_pkg::MUX_TEMP;
         end
         default: begin
            gain      = cfg.voltage_gain;
            bias      = cfg.voltage_bias;
            alpha_raw = cfg.temp_alpha;
            ch_in     = adcsss_pkg::CH_VOLT;
            mux_next  = adcsss_pkg::MUX_VOLT;
         end
      endcase
   end

   // alpha above one acts as one
   assign alpha = alpha_raw[16] ? adcsss_pkg::ALPHA_ONE : alpha_raw;

   // load: millivolts plus bias, or calibration offset less a quarter of the sample
   assign mv    = 28'(req_sample) * 28'(adcsss_pkg::MV_PER_LSB_Q16);
   assign vsum  = $signed({6'd0, mv}) + $signed({{2{bias[23]}}, bias, 8'd0});
   assign tdiff = {16'd0, cfg.temp_calibration[31:16]} - {20'd0, req_sample[13:2]};

   // shared multiplier
   assign mul_a = opa_ff;
   always_comb begin
      if (cmd.smooth) begin
         mul_b = $signed({1'b0, alpha});
      end else if (is_temp) begin
         mul_b = $signed({2'd0, cfg.temp_calibration[15:0]});
      end else begin
         mul_b = $signed({2'd0, gain});
      end
   end
   assign mul_p = mul_a * mul_b;

   // value: temperature in Celsius or scaled reading, then step from average
   assign tround = prod_ff[31:0] + adcsss_pkg::TEMP_ROUND;
   assign tval   = $signed({1'b0, tround[27:12], 16'd0}) - adcsss_pkg::KELVIN_Q16;
   assign gval   = (prod_ff + adcsss_pkg::GAIN_ROUND) >>> 8;
   assign value  = is_temp ? sat32({{19{tval[32]}}, tval}) : sat32(gval);
   assign diff   = {value[31], value} - {avg_cur[31], avg_cur};

   always_comb begin
      if (cmd.load) begin
         opa_in = is_temp ? $signed({2'd0, tdiff}) : vsum;
      end else if (cmd.value) begin
         opa_in = {diff[32], diff};
      end else begin
         opa_in = opa_ff;
      end
   end

   // avg*(1-a) + v*a equals avg + (v-avg)*a, in units of 2^-16
   assign acc     = $signed({{4{avg_cur[31]}}, avg_cur, 16'd0}) + prod_ff
                    + adcsss_pkg::SMOOTH_ROUND;
   assign avg_new = sat32(acc >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff     <= adcsss_pkg::CH_TEMP;
         avg_ff[0] <= '0;
         avg_ff[1] <= '0;
         avg_ff[2] <= '0;
      end else if (cmd.commit) begin
         ch_ff       <= ch_in;
         avg_ff[chn] <= avg_new;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      if (cmd.scale || cmd.smooth) begin
         prod_ff <= mul_p;
      end
      if (cmd.commit) begin
         rsp_channel_ff <= chn;
         rsp_value_ff   <= avg_new;
         rsp_mux_ff     <= mux_next;
      end
   end

   assign rsp_channel        = rsp_channel_ff;
   assign rsp_smoothed_value = rsp_value_ff;
   assign rsp_next_mux       = rsp_mux_ff;

   a_ptr_legal: assert property (@(posedge clock) disable iff (reset)
      ch_ff != 2'd3)
      else $error("channel pointer left the scan range");

   a_ptr_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (ch_ff != $past(ch_ff)))
      else $error("channel pointer did not advance on update");

endmodule

FILE: tb/sv/adcsss_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcsss_result_check
// Watches the sample, result and register ports of adc_scan_scale_smooth.
// Keeps its own copy of the registers, the scan pointer and the three channel
// averages, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module adcsss_result_check
   import adcsss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   adcsss_req_if       req_mon,
   adcsss_rsp_if       rsp_mon,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned results_seen
);

   typedef struct packed {
      logic [1:0]         channel;
      logic signed [31:0] smoothed_value;
      logic [7:0]         next_mux;
   } scan_result_type;

   // register copies
   logic [15:0]        volt_gain_q;
   logic [15:0]        curr_gain_q;
   logic signed [23:0] volt_bias_q;
   logic signed [23:0] curr_bias_q;
   logic [16:0]        temp_alpha_q;
   logic [16:0]        volt_alpha_q;
   logic [16:0]        curr_alpha_q;
   logic [31:0]        temp_cal_q;

   logic [1:0]         scan_ch;
   logic signed [31:0] avg_q [3];

   scan_result_type    expected_beats [$];
   scan_result_type    predicted;
   scan_result_type    observed;
   int unsigned        mismatches = 0;
   int unsigned        beats_checked = 0;

   function automatic logic signed [31:0] clip32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic void report_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // Advance the scan by one sample and return the beat it should produce.
   function automatic scan_result_type advance_scan(input logic [13:0] s);
      scan_result_type r;
      logic [1:0]   ch;
      logic [31:0]  t;
      logic [15:0]  kelvin;
      logic [16:0]  alpha_raw;
      longint       k_ext;
      longint       s_ext;
      longint       gain;
      longint       bias;
      longint       alpha;
      longint       value;
      longint       old_avg;
      longint       acc;
      ch = (scan_ch == 2'd3) ? CH_TEMP : scan_ch;
      if (ch == CH_TEMP) begin
         // offset minus sample/4, times slope, all in 32-bit wrap
         t = {16'd0, temp_cal_q[31:16]} - {20'd0, s[13:2]};
         t = t * {16'd0, temp_cal_q[15:0]};
         t = t + TEMP_ROUND;
         kelvin = t[27:12];
         k_ext = kelvin;
         value = clip32(k_ext * 65536 - 64'sd17901158);
         alpha_raw = temp_alpha_q;
      end else begin
         s_ext = s;
         gain  = (ch == CH_VOLT) ? volt_gain_q : curr_gain_q;
         bias  = (ch == CH_VOLT) ? volt_bias_q : curr_bias_q;
         value = clip32(((s_ext * 10000 + bias * 256) * gain + 128) >>> 8);
         alpha_raw = (ch == CH_VOLT) ? volt_alpha_q : curr_alpha_q;
      end
      alpha = (alpha_raw > ALPHA_ONE) ? 65536 : alpha_raw;
      old_avg = avg_q[ch];
      acc = old_avg * (65536 - alpha) + value * alpha + 32768;
      avg_q[ch] = clip32(acc >>> 16);
      scan_ch = (ch >= CH_CURR) ? CH_TEMP : ch + 2'd1;
      r.channel = ch;
      r.smoothed_value = avg_q[ch];
      case (scan_ch)
         CH_VOLT: r.next_mux = MUX_VOLT;
         CH_CURR: r.next_mux = MUX_CURR;
         default: r.next_mux = MUX_TEMP;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         volt_gain_q  = VOLTAGE_GAIN_RST;
         curr_gain_q  = CURRENT_GAIN_RST;
         volt_bias_q  = VOLTAGE_BIAS_RST;
         curr_bias_q  = CURRENT_BIAS_RST;
         temp_alpha_q = TEMP_ALPHA_RST;
         volt_alpha_q = VOLTAGE_ALPHA_RST;
         curr_alpha_q = CURRENT_ALPHA_RST;
         temp_cal_q   = TEMP_CAL_RST;
         scan_ch      = CH_TEMP;
         foreach (avg_q[i]) avg_q[i] = '0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VOLTAGE_GAIN:  volt_gain_q  = csr_wdata[15:0];
               REG_CURRENT_GAIN:  curr_gain_q  = csr_wdata[15:0];
               REG_VOLTAGE_BIAS:  volt_bias_q  = csr_wdata[23:0];
               REG_CURRENT_BIAS:  curr_bias_q  = csr_wdata[23:0];
               REG_TEMP_ALPHA:    temp_alpha_q = csr_wdata[16:0];
               REG_VOLTAGE_ALPHA: volt_alpha_q = csr_wdata[16:0];
               REG_CURRENT_ALPHA: curr_alpha_q = csr_wdata[16:0];
               REG_TEMP_CAL:      temp_cal_q   = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted = advance_scan(req_mon.sample);
            expected_beats.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.channel        = rsp_mon.channel;
            observed.smoothed_value = rsp_mon.smoothed_value;
            observed.next_mux       = rsp_mon.next_mux;
            beats_checked++;
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected result beat", 32'd0, observed.smoothed_value);
            end else begin
               predicted = expected_beats.pop_front();
               if (observed.channel !== predicted.channel)
                  report_mismatch("channel", predicted.channel, observed.channel);
               if (observed.smoothed_value !== predicted.smoothed_value)
                  report_mismatch("smoothed_value", predicted.smoothed_value,
                                  observed.smoothed_value);
               if (observed.next_mux !== predicted.next_mux)
                  report_mismatch("next_mux", predicted.next_mux, observed.next_mux);
            end
         end
      end
      fail_count   <= mismatches;
      pending      <= expected_beats.size();
      results_seen <= beats_checked;
   end

endmodule

FILE: tb/sv/tb_adc_scan_scale_smooth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_scan_scale_smooth
// Drives converter samples and register writes into adc_scan_scale_smooth.
// A short directed pass covers reset defaults, field extremes, alpha above
// one, Kelvin saturation and wrapped calibration offsets; random register
// settings and samples follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_adc_scan_scale_smooth;
   import adcsss_pkg::*;

   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_SAMPLES = 188;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   adcsss_req_if req_bus ();
   adcsss_rsp_if rsp_bus ();

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_seen;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   int unsigned samples_sent = 0;
   int unsigned settings_loaded = 0;
   bit          quiet_tail = 1'b0;

   adc_scan_scale_smooth dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   adcsss_result_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: stall in bursts, with calm stretches and none at the tail.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet_tail && ((cycle_count / 256) % 3 != 2)
                   && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic [13:0] s);
      if (!quiet_tail && ((cycle_count / 320) % 3 != 1) && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
   endtask

   // Drop valid and wait until every predicted beat has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_reg(input reg_index_type idx, input logic [31:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic load_registers(input cfg_type c, input bit junk_high);
      logic [31:0] pad;
      pad = junk_high ? $urandom : 32'd0;
      put_reg(REG_VOLTAGE_GAIN,  {pad[15:0], c.voltage_gain});
      put_reg(REG_CURRENT_GAIN,  {pad[31:16], c.current_gain});
      put_reg(REG_VOLTAGE_BIAS,  {pad[7:0], c.voltage_bias});
      put_reg(REG_CURRENT_BIAS,  {pad[15:8], c.current_bias});
      put_reg(REG_TEMP_ALPHA,    {pad[14:0], c.temp_alpha});
      put_reg(REG_VOLTAGE_ALPHA, {pad[29:15], c.voltage_alpha});
      put_reg(REG_CURRENT_ALPHA, {pad[16:2], c.current_alpha});
      put_reg(REG_TEMP_CAL,      c.temp_calibration);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 1024));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_bias();
      case ($urandom_range(0, 5))
         0:       return 24'h80_0000;
         1:       return 24'h7F_FFFF;
         2:       return 24'($signed($urandom_range(0, 2048)) - 1024);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] pick_alpha();
      case ($urandom_range(0, 6))
         0:       return 17'd0;
         1:       return ALPHA_ONE;
         2:       return 17'($urandom_range(65537, 131071));
         3:       return 17'($urandom_range(1, 4096));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [31:0] pick_calibration();
      case ($urandom_range(0, 4))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'h0000_0000;
         2:       return {16'($urandom), 16'($urandom_range(0, 255))};
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.voltage_gain     = pick_gain();
      c.current_gain     = pick_gain();
      c.voltage_bias     = pick_bias();
      c.current_bias     = pick_bias();
      c.temp_alpha       = pick_alpha();
      c.voltage_alpha    = pick_alpha();
      c.current_alpha    = pick_alpha();
      c.temp_calibration = pick_calibration();
      return c;
   endfunction

   function automatic logic [13:0] random_sample();
      case ($urandom_range(0, 15))
         0:       return 14'h0000;
         1:       return 14'h3FFF;
         default: return 14'($urandom_range(0, 16383));
      endcase
   endfunction

   initial begin
      cfg_type     corner;
      logic [13:0] reset_scan [9];
      logic [13:0] corner_scan [6];

      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, three full scans
      reset_scan = '{14'h0000, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h0000, 14'h0000,
                     14'h2AAA, 14'h1555, 14'h2000};
      foreach (reset_scan[i]) send_sample(reset_scan[i]);
      drain_results();

      // top gain and bias on voltage, alpha above one, Kelvin saturation
      corner = '{voltage_gain: 16'hFFFF, current_gain: 16'h0000,
                 voltage_bias: 24'h7F_FFFF, current_bias: 24'h80_0000,
                 temp_alpha: ALPHA_ONE, voltage_alpha: 17'h1_FFFF,
                 current_alpha: 17'd0, temp_calibration: 32'hFFFF_FFFF};
      load_registers(corner, 1'b0);
      corner_scan = '{14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h0000, 14'h0000, 14'h0000};
      foreach (corner_scan[i]) send_sample(corner_scan[i]);
      drain_results();

      // offset below sample/4 wraps; bottom bias on voltage
      corner = '{voltage_gain: 16'h0000, current_gain: 16'hFFFF,
                 voltage_bias: 24'h80_0000, current_bias: 24'h7F_FFFF,
                 temp_alpha: 17'd0, voltage_alpha: 17'd1,
                 current_alpha: 17'd65537, temp_calibration: 32'h0000_FFFF};
      load_registers(corner, 1'b0);
      corner_scan = '{14'h3FFF, 14'h0000, 14'h3FFF, 14'h0004, 14'h3FFF, 14'h0000};
      foreach (corner_scan[i]) send_sample(corner_scan[i]);
      drain_results();

      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) quiet_tail = 1'b1;
         load_registers(random_settings(), phase[0]);
         repeat (PHASE_SAMPLES) send_sample(random_sample());
         drain_results();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d samples under %0d register settings; %0d result beats checked",
               samples_sent, settings_loaded, results_seen);
      $display("Mismatches: %0d, cycles: %0d", fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/adcsss_pkg.sv
rtl/adcsss_if.sv
rtl/adcsss_csr.sv
rtl/adcsss_ctrl.sv
rtl/adcsss_dp.sv
rtl/adc_scan_scale_smooth.sv
tb/sv/adcsss_result_check.sv
tb/sv/tb_adc_scan_scale_smooth.sv
